// ----- sv/rptb_pkg.sv -----
// ----------------------------------------------------------------------------
// rptb_pkg: shared types and constants of the relay pulse timer bank
// Command codes, register map, reset values and the beat structures that
// pass between the top level, the relay lanes and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rptb_pkg;

  localparam int NUM_RELAYS_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_WIDTH  = 16;
  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;
  localparam int OUT_BITS   = 8;

  localparam logic [CFG_WIDTH-1:0] SHORT_RESET = 16'd250;
  localparam logic [CFG_WIDTH-1:0] LONG_RESET  = 16'd5500;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_SET_ONE = 2'd1,
    ACT_SET_ALL = 2'd2,
    ACT_TOGGLE  = 2'd3
  } action_t;

  // Word index of a register, taken from paddr[2].
  typedef enum logic {
    REG_SHORT_PULSE = 1'b0,
    REG_LONG_PULSE  = 1'b1
  } reg_index_t;

  // Per-lane command, already decoded and gated by the input handshake.
  typedef struct packed {
    logic tick;
    logic set;
    logic toggle;
    logic target;
  } lane_cmd_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] drive;
    logic [OUT_BITS-1:0] status;
    logic                changed;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/relay_pulse_timer_bank.sv -----
// ----------------------------------------------------------------------------
// relay_pulse_timer_bank: bank of relay pulse timers
// Energizes power-button relays for a programmed number of ticks.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (in_valid, in_stall, action, relay_index, target_on)
//   carries ticks, set-one, set-all and toggle commands. Every accepted beat
//   produces exactly one result beat on the output channel (out_valid,
//   out_stall, relay_drive, relay_status, status_changed) showing the coil
//   and status vectors after that command.
//   All relay lanes update in parallel in the cycle a beat is accepted, so
//   the block takes one beat per cycle while in_stall is low, and each
//   result is registered in the output stage. A two-entry output stage lets one more beat enter
//   while the receiver stalls; in_stall rises only when both entries hold
//   results and falls as soon as the receiver takes one.
//   Pulse lengths are written over the APB port: byte address 0 for the
//   switch-on pulse, byte address 4 for the force-off pulse.
//   Reset clears every relay to off and idle, empties the output stage and
//   restores pulse lengths of 250 and 5500 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_pulse_timer_bank #(
  parameter int NUM_RELAYS  = rptb_pkg::NUM_RELAYS_DEF,
  parameter int COUNT_WIDTH = rptb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // APB configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rptb_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [rptb_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic      [rptb_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                                   pready,
  // Command channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        action,
  input  wire logic [2:0]                        relay_index,
  input  wire logic                              target_on,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [rptb_pkg::OUT_BITS-1:0]     relay_drive,
  output logic      [rptb_pkg::OUT_BITS-1:0]     relay_status,
  output logic                                   status_changed
);

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [rptb_pkg::CFG_WIDTH-1:0] short_pulse_ticks;
  logic [rptb_pkg::CFG_WIDTH-1:0] long_pulse_ticks;
  logic                           cfg_write;
  rptb_pkg::reg_index_t           reg_index;

  logic [31:0]            short_wide;
  logic [31:0]            long_wide;
  logic [COUNT_WIDTH-1:0] short_count;
  logic [COUNT_WIDTH-1:0] long_count;

  logic                   accept;
  logic                   is_tick;
  logic                   is_set_one;
  logic                   is_set_all;
  logic                   is_toggle;
  logic [NUM_RELAYS-1:0]  coil_next;
  logic [NUM_RELAYS-1:0]  status_next;
  logic [NUM_RELAYS-1:0]  released;

  rptb_pkg::result_t      result;
  rptb_pkg::result_t      out_data;

  // Configuration registers
  assign pready    = 1'b1;
  assign reg_index = rptb_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_pulse_ticks <= rptb_pkg::SHORT_RESET;
      long_pulse_ticks  <= rptb_pkg::LONG_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        rptb_pkg::REG_SHORT_PULSE: short_pulse_ticks <= pwdata[rptb_pkg::CFG_WIDTH-1:0];
        rptb_pkg::REG_LONG_PULSE:  long_pulse_ticks  <= pwdata[rptb_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rptb_pkg::REG_SHORT_PULSE: prdata = 32'(short_pulse_ticks);
      rptb_pkg::REG_LONG_PULSE:  prdata = 32'(long_pulse_ticks);
      default:                   prdata = '0;
    endcase
  end

  // A narrow counter saturates pulse lengths that do not fit.
  assign short_wide  = 32'(short_pulse_ticks);
  assign long_wide   = 32'(long_pulse_ticks);
  assign short_count = COUNT_WIDTH'((short_wide > CountMax) ? CountMax : short_wide);
  assign long_count  = COUNT_WIDTH'((long_wide > CountMax) ? CountMax : long_wide);

  // Command decode
  assign accept     = in_valid && !in_stall;
  assign is_tick    = accept && (action == rptb_pkg::ACT_TICK);
  assign is_set_one = accept && (action == rptb_pkg::ACT_SET_ONE);
  assign is_set_all = accept && (action == rptb_pkg::ACT_SET_ALL);
  assign is_toggle  = accept && (action == rptb_pkg::ACT_TOGGLE);

  for (genvar i = 0; i < NUM_RELAYS; i++) begin : g_lane
    rptb_pkg::lane_cmd_t lane_cmd;
    logic                addressed;

    // An index beyond the bank addresses no lane, so the command drops out.
    assign addressed       = (32'(relay_index) == i);
    assign lane_cmd.tick   = is_tick;
    assign lane_cmd.set    = is_set_all || (is_set_one && addressed);
    assign lane_cmd.toggle = is_toggle && addressed;
    assign lane_cmd.target = target_on;

    rptb_relay_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .cmd         (lane_cmd),
      .short_count (short_count),
      .long_count  (long_count),
      .coil_next   (coil_next[i]),
      .status_next (status_next[i]),
      .released    (released[i])
    );
  end

  // Only the first eight relays are visible on the result fields.
  for (genvar i = 0; i < rptb_pkg::OUT_BITS; i++) begin : g_view
    if (i < NUM_RELAYS) begin : g_on
      assign result.drive[i]  = coil_next[i];
      assign result.status[i] = status_next[i];
    end else begin : g_off
      assign result.drive[i]  = 1'b0;
      assign result.status[i] = 1'b0;
    end
  end

  assign result.changed = is_tick && (|released);

  rptb_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign relay_drive    = out_data.drive;
  assign relay_status   = out_data.status;
  assign status_changed = out_data.changed;

endmodule

`default_nettype wire

// ----- sv/rptb_relay_lane.sv -----
// ----------------------------------------------------------------------------
// rptb_relay_lane: pulse timer of one relay
// Holds the countdown, pending target, recorded status and coil state of a
// single relay, and computes their next values for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module rptb_relay_lane #(
  parameter int COUNT_WIDTH = rptb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rptb_pkg::lane_cmd_t    cmd,
  input  wire logic [COUNT_WIDTH-1:0] short_count,
  input  wire logic [COUNT_WIDTH-1:0] long_count,
  output logic                        coil_next,
  output logic                        status_next,
  output logic                        released
);

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   pending;
  logic                   pending_next;
  logic                   coil;
  logic                   status;
  logic                   start;
  logic                   start_target;

  always_comb begin
    count_next   = count;
    pending_next = pending;
    coil_next    = coil;
    status_next  = status;
    released     = 1'b0;
    start        = 1'b0;
    start_target = 1'b0;

    // A countdown already at zero releases on this tick rather than wrapping.
    if (cmd.tick && coil) begin
      if (count == '0) begin
        coil_next   = 1'b0;
        status_next = pending;
        released    = 1'b1;
      end else begin
        count_next = count - COUNT_WIDTH'(1);
      end
    end

    if (cmd.set && (status != cmd.target)) begin
      start        = 1'b1;
      start_target = cmd.target;
    end

    if (cmd.toggle) begin
      start        = 1'b1;
      start_target = ~status;
    end

    if (start) begin
      count_next   = start_target ? short_count : long_count;
      pending_next = start_target;
      coil_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pending <= 1'b0;
      coil    <= 1'b0;
      status  <= 1'b0;
    end else begin
      count   <= count_next;
      pending <= pending_next;
      coil    <= coil_next;
      status  <= status_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rptb_out_skid.sv -----
// ----------------------------------------------------------------------------
// rptb_out_skid: two-entry output stage
// An output register backed by a skid register, so that one result beat can
// be taken in while the receiver stalls the beat in front of it.
// ----------------------------------------------------------------------------
`default_nettype none

module rptb_out_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rptb_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rptb_pkg::result_t      out_data
);

  rptb_pkg::result_t skid_data;
  logic              skid_valid;
  logic              out_free;

  // The output register can take a new beat when it is empty or being read.
  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (!out_free && push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rptb_checker.sv -----
// ----------------------------------------------------------------------------
// rptb_checker: port-level checks of the relay pulse timer bank
// Watches the top level's ports for handshake and output-stage behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module rptb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] relay_drive,
  input wire logic [7:0] relay_status,
  input wire logic       status_changed
);

  // The output stage comes out of reset empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output stage not empty after reset");

  // In the cycle after a command beat is accepted, out_valid is high.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  // The input side stalls only while results are waiting at the output.
  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result beat withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(relay_drive) && $stable(relay_status) && $stable(status_changed)))
    else $error("stalled result beat changed");

endmodule

bind relay_pulse_timer_bank rptb_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .relay_drive    (relay_drive),
  .relay_status   (relay_status),
  .status_changed (status_changed)
);

`default_nettype wire
